@@ src/mdcc_pkg.sv @@
// Shared types, constants and helper functions of the display column capture block.
package mdcc_pkg;

  localparam int unsigned KIND_W = 2;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned PLANE_W = 2;
  localparam int unsigned GROUP_W = 2;
  localparam int unsigned COL_W = 3;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned MODE_W = 2;

  localparam int unsigned WORD_W = 7;
  localparam int unsigned RING_LEN = 7;
  localparam int unsigned POS_W = 3;
  localparam int unsigned FRAME_W = 2;
  localparam int unsigned PLANES = 4;
  localparam int unsigned GROUPS = 3;
  localparam int unsigned COLS = 8;
  localparam int unsigned NUM_BANKS = PLANES * GROUPS;
  localparam int unsigned BANK_W = $clog2(NUM_BANKS);

  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [BYTE_W-1:0] LAMP_STROBE = 8'h7e;
  localparam logic [BYTE_W-1:0] LAMP_RESYNC = 8'h30;
  localparam int unsigned STROBE_BIT = 7;
  localparam int unsigned RESYNC_BIT = 6;
  localparam logic [GROUP_W-1:0] GROUP_NONE = 2'd3;

  localparam logic [MODE_W-1:0] MODE_NONE = 2'd0;
  localparam logic [MODE_W-1:0] MODE_FOUR = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEVEN = 2'd2;
  localparam logic [MODE_W-1:0] MODE_LED = 2'd3;

  typedef enum logic [KIND_W-1:0] {
    KIND_LATCH_WR = 2'd0,
    KIND_STROBE   = 2'd1,
    KIND_LATCH_RD = 2'd2,
    KIND_WORD_RD  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [BYTE_W-1:0]   value;
    logic [PLANE_W-1:0]  plane;
    logic [GROUP_W-1:0]  row_group;
    logic [COL_W-1:0]    column;
    logic                word_hit;
    logic                lamp_strobe;
  } cmd_t;

  function automatic logic [BANK_W-1:0] bank_idx(logic [PLANE_W-1:0] plane,
                                                 logic [GROUP_W-1:0] group);
    return BANK_W'(plane) * BANK_W'(GROUPS) + BANK_W'(group);
  endfunction

  function automatic logic [COL_W-1:0] msb5(logic [4:0] t);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = 0; i < 5; i++) begin
      if (t[i]) idx = COL_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [COL_W-1:0] lsb7(logic [WORD_W-1:0] w);
    logic [COL_W-1:0] idx;
    idx = '0;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (w[i]) idx = COL_W'(i);
    end
    return idx;
  endfunction

  function automatic logic [SLOT_W-1:0] lamp_slot_f(logic [POS_W-1:0] p);
    logic [SLOT_W-1:0] s;
    unique case (p)
      3'd0:    s = 3'd6;
      3'd1:    s = 3'd2;
      3'd2:    s = 3'd4;
      3'd3:    s = 3'd5;
      3'd4:    s = 3'd1;
      3'd5:    s = 3'd3;
      default: s = 3'd0;
    endcase
    return s;
  endfunction

endpackage

@@ src/mdcc_if.sv @@
// Valid/ready channel interfaces for bus accesses in and results out.
interface mdcc_in_if import mdcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [BYTE_W-1:0]   value;
  logic [PLANE_W-1:0]  plane;
  logic [GROUP_W-1:0]  row_group;
  logic [COL_W-1:0]    column;

  modport source (output valid, kind, value, plane, row_group, column, input ready);
  modport sink (input valid, kind, value, plane, row_group, column, output ready);
endinterface

interface mdcc_out_if import mdcc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [BYTE_W-1:0]   read_data;
  logic                lamp_write;
  logic [SLOT_W-1:0]   lamp_slot;
  logic [BYTE_W-1:0]   lamp_value;

  modport source (output valid, read_data, lamp_write, lamp_slot, lamp_value, input ready);
  modport sink (input valid, read_data, lamp_write, lamp_slot, lamp_value, output ready);
endinterface

@@ src/mdcc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module mdcc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ src/mdcc_front.sv @@
// Front end: accept bus accesses, classify them and register them for the queue.
module mdcc_front import mdcc_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  mdcc_in_if.sink in_i,
  output logic  push_valid_o,
  input  logic  push_ready_i,
  output cmd_t  push_cmd_o
);

  logic vld_q, vld_d;
  cmd_t cmd_q, cmd_d;
  logic take;

  assign in_i.ready = !vld_q || push_ready_i;
  assign take = in_i.valid && in_i.ready;

  always_comb begin
    cmd_d.kind        = kind_e'(in_i.kind);
    cmd_d.value       = in_i.value;
    cmd_d.plane       = in_i.plane;
    cmd_d.row_group   = in_i.row_group;
    cmd_d.column      = in_i.column;
    cmd_d.word_hit    = in_i.row_group != GROUP_NONE;
    cmd_d.lamp_strobe = in_i.value == LAMP_STROBE;
  end

  always_comb begin
    vld_d = vld_q;
    if (take) begin
      vld_d = 1'b1;
    end else if (push_ready_i) begin
      vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cmd_q <= cmd_d;
    end
  end

  assign push_valid_o = vld_q;
  assign push_cmd_o   = cmd_q;

endmodule

@@ src/mdcc_queue.sv @@
// Short command queue between the front end and the back end.
module mdcc_queue import mdcc_pkg::*; #(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_valid_i,
  output logic push_ready_o,
  input  cmd_t push_cmd_i,
  output logic pop_valid_o,
  input  logic pop_ready_i,
  output cmd_t pop_cmd_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_t             slot_q [DEPTH];
  logic [PTR_W-1:0] wptr_q, wptr_d, rptr_q, rptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             push, pop;

  assign push_ready_o = cnt_q != CNT_W'(DEPTH);
  assign pop_valid_o  = cnt_q != '0;
  assign push = push_valid_i && push_ready_o;
  assign pop  = pop_valid_o && pop_ready_i;
  assign pop_cmd_o = slot_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (push) begin
      wptr_d = (wptr_q == PTR_W'(DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
    end
    if (pop) begin
      rptr_d = (rptr_q == PTR_W'(DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
    end
    if (push && !pop) begin
      cnt_d = cnt_q + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_d = cnt_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wptr_q] <= push_cmd_i;
    end
  end

endmodule

@@ src/mdcc_back.sv @@
// Back end: display state, strobe handling, column store banks and result register.
module mdcc_back import mdcc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i,
  input  logic              pop_valid_i,
  output logic              pop_ready_o,
  input  cmd_t              pop_cmd_i,
  mdcc_out_if.source        out_o
);

  logic [MODE_W-1:0]  mode_q;
  logic [BYTE_W-1:0]  latch_q, latch_d;
  logic [BYTE_W-1:0]  last_q, last_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [FRAME_W-1:0] frame_q, frame_d;
  logic [WORD_W-1:0]  ring_q [RING_LEN];
  logic [WORD_W-1:0]  ring_d [RING_LEN];
  logic [NUM_BANKS-1:0][COLS-1:0] vld_q;

  logic               pop;
  logic               rise;
  logic [1:0]         p_four;
  logic [4:0]         t_four;
  logic [POS_W-1:0]   p_seven;
  logic [POS_W-1:0]   pos_a, p_led;
  logic [SLOT_W-1:0]  slot;
  logic [GROUP_W-1:0] g_seven;
  logic               found;
  logic [COL_W-1:0]   col;
  logic [BANK_W-1:0]  bank_sel;

  logic [NUM_BANKS-1:0] bank_we;
  logic [WORD_W-1:0]    bank_wdata [NUM_BANKS];
  logic [WORD_W-1:0]    bank_rdata [NUM_BANKS];
  logic                 word_re;

  logic               out_vld_q, out_vld_d;
  logic               rd_word_q, rd_word_d;
  logic               hit_q, hit_d;
  logic [BANK_W-1:0]  sel_q;
  logic [BYTE_W-1:0]  rd_byte_q, rd_byte_d;
  logic               lamp_we_q, lamp_we_d;
  logic [SLOT_W-1:0]  lamp_slot_q, lamp_slot_d;
  logic [BYTE_W-1:0]  lamp_val_q, lamp_val_d;

  assign pop_ready_o = !out_vld_q || out_o.ready;
  assign pop = pop_valid_i && pop_ready_o;
  assign bank_sel = bank_idx(pop_cmd_i.plane, pop_cmd_i.row_group);

  always_comb begin
    latch_d = latch_q;
    last_d  = last_q;
    pos_d   = pos_q;
    frame_d = frame_q;
    ring_d  = ring_q;
    bank_we = '0;
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_wdata[b] = '0;
    end
    col         = pop_cmd_i.column;
    word_re     = 1'b0;
    rd_word_d   = 1'b0;
    rd_byte_d   = '0;
    hit_d       = 1'b0;
    lamp_we_d   = 1'b0;
    lamp_slot_d = '0;
    lamp_val_d  = '0;
    rise    = pop_cmd_i.value[STROBE_BIT] && !last_q[STROBE_BIT];
    p_four  = pos_q[1:0] + 2'd1;
    t_four  = '0;
    p_seven = (pos_q == POS_W'(RING_LEN - 1)) ? '0 : pos_q + POS_W'(1);
    g_seven = '0;
    found   = 1'b0;
    pos_a   = (latch_q == LAMP_RESYNC && last_q[RESYNC_BIT]) ? '0 : pos_q;
    p_led   = (pos_a > POS_W'(RING_LEN - 1)) ? POS_W'(RING_LEN - 1) : pos_a;
    slot    = lamp_slot_f(p_led);
    if (pop) begin
      unique case (pop_cmd_i.kind)
        KIND_LATCH_WR: begin
          latch_d = pop_cmd_i.value;
        end
        KIND_STROBE: begin
          unique case (mode_q)
            MODE_NONE: begin
            end
            MODE_FOUR: begin
              last_d = pop_cmd_i.value;
              if (rise) begin
                ring_d[pos_q] = latch_q[WORD_W-1:0];
                pos_d  = {1'b0, p_four};
                t_four = ring_d[{1'b0, p_four}][4:0];
                if (!latch_q[STROBE_BIT] && t_four != '0) begin
                  col = msb5(t_four);
                  for (int g = 0; g < GROUPS; g++) begin
                    bank_we[bank_idx(frame_q, GROUP_W'(g))] = 1'b1;
                    bank_wdata[bank_idx(frame_q, GROUP_W'(g))] =
                      ring_d[{1'b0, p_four + 2'(g + 1)}];
                  end
                  if (col == COL_W'(4)) begin
                    frame_d = (frame_q == 2'd2) ? 2'd0 :
                              (frame_q == 2'd3) ? 2'd1 : frame_q + 2'd1;
                  end
                end
              end
            end
            MODE_SEVEN: begin
              last_d = pop_cmd_i.value;
              if (rise) begin
                pos_d = p_seven;
                ring_d[p_seven] = latch_q[WORD_W-1:0];
                if (!latch_q[STROBE_BIT]) begin
                  if (ring_d[4] != '0) begin
                    found   = 1'b1;
                    g_seven = 2'd0;
                    col     = lsb7(ring_d[4]);
                  end else if (ring_d[3] != '0) begin
                    found   = 1'b1;
                    g_seven = 2'd1;
                    col     = lsb7(ring_d[3]);
                  end
                  if (found) begin
                    bank_we[bank_idx(2'd0, g_seven)] = 1'b1;
                    bank_we[bank_idx(2'd1, g_seven)] = 1'b1;
                    bank_we[bank_idx(2'd2, g_seven)] = 1'b1;
                    bank_we[bank_idx(2'd3, g_seven)] = 1'b1;
                    bank_wdata[bank_idx(2'd0, g_seven)] = ring_d[0];
                    bank_wdata[bank_idx(2'd1, g_seven)] = ring_d[1];
                    bank_wdata[bank_idx(2'd2, g_seven)] = ring_d[5];
                    bank_wdata[bank_idx(2'd3, g_seven)] = ring_d[6];
                  end
                end
              end
            end
            MODE_LED: begin
              last_d = latch_q;
              pos_d  = pos_a;
              if (pop_cmd_i.lamp_strobe) begin
                if (slot != '0) begin
                  lamp_we_d   = 1'b1;
                  lamp_slot_d = slot;
                  lamp_val_d  = latch_q;
                end
                pos_d = (p_led < POS_W'(RING_LEN - 1)) ? p_led + POS_W'(1) : p_led;
              end
            end
            default: begin
            end
          endcase
        end
        KIND_LATCH_RD: begin
          rd_byte_d = latch_q;
        end
        KIND_WORD_RD: begin
          if (pop_cmd_i.word_hit) begin
            word_re   = 1'b1;
            rd_word_d = 1'b1;
            hit_d     = vld_q[bank_sel][pop_cmd_i.column];
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (pop) begin
      out_vld_d = 1'b1;
    end else if (out_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_NONE;
      latch_q   <= '0;
      last_q    <= '0;
      pos_q     <= '0;
      frame_q   <= '0;
      vld_q     <= '0;
      out_vld_q <= 1'b0;
      for (int i = 0; i < RING_LEN; i++) begin
        ring_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      latch_q   <= latch_d;
      last_q    <= last_d;
      pos_q     <= pos_d;
      frame_q   <= frame_d;
      ring_q    <= ring_d;
      out_vld_q <= out_vld_d;
      for (int b = 0; b < NUM_BANKS; b++) begin
        if (bank_we[b]) begin
          vld_q[b][col] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      rd_word_q   <= rd_word_d;
      hit_q       <= hit_d;
      sel_q       <= bank_sel;
      rd_byte_q   <= rd_byte_d;
      lamp_we_q   <= lamp_we_d;
      lamp_slot_q <= lamp_slot_d;
      lamp_val_q  <= lamp_val_d;
    end
  end

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_bank
    mdcc_ram #(
      .WIDTH (WORD_W),
      .DEPTH (COLS)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (bank_we[b]),
      .waddr_i (col),
      .wdata_i (bank_wdata[b]),
      .re_i    (word_re),
      .raddr_i (pop_cmd_i.column),
      .rdata_o (bank_rdata[b])
    );
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.read_data  = rd_word_q ? (hit_q ? {1'b0, bank_rdata[sel_q]} : '0) : rd_byte_q;
  assign out_o.lamp_write = lamp_we_q;
  assign out_o.lamp_slot  = lamp_slot_q;
  assign out_o.lamp_value = lamp_val_q;

endmodule

@@ src/mini_display_column_capture_unit.sv @@
// Top level of the display column capture block: front end, queue and back end.
//
// The host drives one bus access per word on in_i (valid/ready): write the
// data latch, write the strobe register, read back the latch, or read one
// stored 7-bit column word. Every access yields exactly one result word on
// out_o (valid/ready) carrying read_data and the lamp column write fields.
// The host must load display_mode through cfg_we_i/cfg_wdata_i only while
// the block is idle; the block itself does not enforce this.
// Throughput is one word per cycle while out_o.ready is high: the front
// register, the queue and the back end each move one word a cycle, and all
// strobe handling (ring update, column search, up to four bank writes)
// completes in the back end's cycle. An accepted word passes through the front
// register, a queue slot and the result register. Column words come from
// twelve 8-entry banks with registered read, indexed by plane and row group.
//
// Reset clears all state; per-word valid bits make the whole store read as
// zero at once, so there is no clearing pass. A stalled receiver holds the
// result register; the queue then fills and in_i.ready drops after at most
// QUEUE_DEPTH + 1 further words.
module mini_display_column_capture_unit import mdcc_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  mdcc_in_if.sink           in_i,
  mdcc_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [MODE_W-1:0] cfg_wdata_i
);

  logic push_valid, push_ready;
  logic pop_valid, pop_ready;
  cmd_t push_cmd, pop_cmd;

  mdcc_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_i         (in_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_cmd_o   (push_cmd)
  );

  mdcc_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (push_cmd),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_cmd_o    (pop_cmd)
  );

  mdcc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .pop_cmd_i   (pop_cmd),
    .out_o       (out_o)
  );

  a_pop_loads_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready |=> out_o.valid)
    else $error("popped word did not reach the result register");

  a_lamp_slot_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.lamp_write |-> out_o.lamp_slot != '0 && out_o.read_data == '0)
    else $error("lamp write with empty slot or read data");

  a_no_lamp_fields_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.lamp_write |-> out_o.lamp_slot == '0 && out_o.lamp_value == '0)
    else $error("lamp fields set without a lamp write");

  a_lamp_only_on_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid && pop_ready && pop_cmd.kind != KIND_STROBE |=> !out_o.lamp_write)
    else $error("lamp write from a non-strobe word");

endmodule
